// ----- hw/rtl/vll_pkg.sv -----
package vll_pkg;

    localparam int unsigned CH_CNT   = 3;
    localparam int unsigned DIR_W    = 16;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned DOT_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [DOT_W-1:0] DOT_MAX = 24'hFFFFFF;
    localparam logic [7:0]       ALPHA   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_DIR_X       = 3'd0,
        REG_LIGHT_DIR_Y       = 3'd1,
        REG_LIGHT_DIR_Z       = 3'd2,
        REG_MAT_AMBIENT_RGB   = 3'd3,
        REG_MAT_EMISSIVE_RGB  = 3'd4,
        REG_MAT_DIFFUSE_RGB   = 3'd5,
        REG_LIGHT_AMBIENT_RGB = 3'd6,
        REG_LIGHT_DIFFUSE_RGB = 3'd7
    } reg_idx_t;

    typedef logic [CH_CNT-1:0][7:0] rgb_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } dir_t;

    // per-channel terms derived from the material and light colors
    typedef struct packed {
        rgb_t amb;
        rgb_t dif;
    } shade_t;

    // floor(p / 255), exact for any product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- hw/rtl/vll_if.sv -----
interface vll_normal_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    output ready);
endinterface

interface vll_color_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb_color;

    modport source (output valid, output argb_color, input ready);
    modport sink   (input valid, input argb_color, output ready);
endinterface

// ----- hw/rtl/vll_cfg.sv -----
module vll_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vll_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vll_pkg::COLOR_W-1:0]       cfg_data,
    output vll_pkg::dir_t                     light_dir,
    output vll_pkg::shade_t                   shade
);

    vll_pkg::dir_t   dir_reg;
    vll_pkg::rgb_t   mat_amb_reg;
    vll_pkg::rgb_t   mat_emi_reg;
    vll_pkg::rgb_t   mat_dif_reg;
    vll_pkg::rgb_t   lgt_amb_reg;
    vll_pkg::rgb_t   lgt_dif_reg;
    vll_pkg::shade_t shade_reg;
    vll_pkg::shade_t shade_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg.x   <= 16'sd0;
            dir_reg.y   <= 16'sd0;
            dir_reg.z   <= 16'sd32767;
            mat_amb_reg <= '0;
            mat_emi_reg <= '0;
            mat_dif_reg <= '1;
            lgt_amb_reg <= '0;
            lgt_dif_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (vll_pkg::reg_idx_t'(cfg_index))
                vll_pkg::REG_LIGHT_DIR_X:       dir_reg.x   <= cfg_data[15:0];
                vll_pkg::REG_LIGHT_DIR_Y:       dir_reg.y   <= cfg_data[15:0];
                vll_pkg::REG_LIGHT_DIR_Z:       dir_reg.z   <= cfg_data[15:0];
                vll_pkg::REG_MAT_AMBIENT_RGB:   mat_amb_reg <= cfg_data;
                vll_pkg::REG_MAT_EMISSIVE_RGB:  mat_emi_reg <= cfg_data;
                vll_pkg::REG_MAT_DIFFUSE_RGB:   mat_dif_reg <= cfg_data;
                vll_pkg::REG_LIGHT_AMBIENT_RGB: lgt_amb_reg <= cfg_data;
                vll_pkg::REG_LIGHT_DIFFUSE_RGB: lgt_dif_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [8:0]  amb_sum;
        logic [7:0]  amb;
        logic [7:0]  dif;
        logic [7:0]  room;
        shade_next = '0;
        for (int c = 0; c < vll_pkg::CH_CNT; c++)
        begin
            amb_sum = {1'b0, vll_pkg::div255(16'(mat_amb_reg[c]) * 16'(lgt_amb_reg[c]))}
                    + {1'b0, mat_emi_reg[c]};
            amb  = amb_sum[8] ? 8'hFF : amb_sum[7:0];
            dif  = vll_pkg::div255(16'(mat_dif_reg[c]) * 16'(lgt_dif_reg[c]));
            room = 8'hFF - amb;
            shade_next.amb[c] = amb;
            shade_next.dif[c] = (dif > room) ? room : dif;
        end
    end

    // terms are registered in the cycle after a write, well ahead of the shading stages
    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
    end

    assign light_dir = dir_reg;
    assign shade     = shade_reg;

endmodule

// ----- hw/rtl/vll_dot.sv -----
module vll_dot (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vll_pkg::dir_t               light_dir,
    vll_normal_if.sink                  normal,
    output logic                        dot_valid,
    input  logic                        dot_ready,
    output logic [vll_pkg::DOT_W-1:0]   dot24
);

    // stage 1: products
    logic               v1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    // stage 2: |sum|
    logic               v2_reg;
    logic [31:0]        mag_reg;
    logic [31:0]        mag_next;
    // stage 3: scaled to 24 bits
    logic               v3_reg;
    logic [vll_pkg::DOT_W-1:0] dot_reg;
    logic [vll_pkg::DOT_W-1:0] dot_next;

    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || dot_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign normal.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= normal.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        logic signed [33:0] s;
        s = {{2{px_reg[31]}}, px_reg} + {{2{py_reg[31]}}, py_reg}
          + {{2{pz_reg[31]}}, pz_reg};
        // |s| <= 3 * 2^30, fits 32 bits
        mag_next = s[33] ? 32'(-s) : s[31:0];
    end

    // dot24 = floor(mag * (2^24 - 1) / 2^30), saturating at DOT_MAX once mag reaches 2^30;
    // below that it is (mag >> 6), minus one when the low six bits scaled by 2^24 fall short of mag
    always_comb
    begin
        logic [23:0] h;
        logic [29:0] low_scaled;
        h          = mag_reg[29:6];
        low_scaled = {mag_reg[5:0], 24'b0};
        if (mag_reg[31:30] != 2'b00)
            dot_next = vll_pkg::DOT_MAX;
        else if (low_scaled >= mag_reg[29:0])
            dot_next = h;
        else
            dot_next = h - 24'd1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            px_reg <= normal.normal_x * light_dir.x;
            py_reg <= normal.normal_y * light_dir.y;
            pz_reg <= normal.normal_z * light_dir.z;
        end
        if (rdy2) mag_reg <= mag_next;
        if (rdy3) dot_reg <= dot_next;
    end

    assign dot_valid = v3_reg;
    assign dot24     = dot_reg;

endmodule

// ----- hw/rtl/vll_shade.sv -----
module vll_shade (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vll_pkg::shade_t             shade,
    input  logic                        dot_valid,
    output logic                        dot_ready,
    input  logic [vll_pkg::DOT_W-1:0]   dot24,
    vll_color_if.source                 color
);

    logic           v4_reg;
    vll_pkg::rgb_t  hi_reg;
    vll_pkg::rgb_t  hi_next;
    logic           v5_reg;
    logic [31:0]    argb_reg;
    logic [31:0]    argb_next;
    logic           rdy4, rdy5;

    assign rdy5 = !v5_reg || color.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign dot_ready = rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4) v4_reg <= dot_valid;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        logic [31:0] prod;
        hi_next = '0;
        for (int c = 0; c < vll_pkg::CH_CNT; c++)
        begin
            prod       = 32'(shade.dif[c]) * 32'(dot24);
            hi_next[c] = prod[31:24];
        end
    end

    // diffuse is clamped to 255 - ambient, so the sum stays in 8 bits
    always_comb
    begin
        vll_pkg::rgb_t rgb;
        logic [8:0]    sum;
        rgb = '0;
        for (int c = 0; c < vll_pkg::CH_CNT; c++)
        begin
            sum    = {1'b0, hi_reg[c]} + {1'b0, shade.amb[c]};
            rgb[c] = sum[7:0];
        end
        argb_next = {vll_pkg::ALPHA, rgb};
    end

    always_ff @(posedge clk)
    begin
        if (rdy4) hi_reg   <= hi_next;
        if (rdy5) argb_reg <= argb_next;
    end

    assign color.valid      = v5_reg;
    assign color.argb_color = argb_reg;

endmodule

// ----- hw/rtl/vertex_lambert_lighting.sv -----
// Per-vertex two-sided Lambert lighting.
// normal: sink channel, one vertex normal (Q1.15 x, y, z) per word.
// color:  source channel, one packed ARGB word per normal, alpha 0xFF.
// cfg_we/cfg_index/cfg_data: register writes, index 0..7 in the order
//   light_dir_x/y/z, mat_ambient, mat_emissive, mat_diffuse,
//   light_ambient, light_diffuse. Write only while no word is in flight.
// Pipeline: five register stages (products, |dot|, 24-bit scale, diffuse
//   multiply, ambient add) carry a normal from the edge that accepts it to
//   the edge at which its color goes valid.
// Throughput: one word per cycle; the five-stage pipeline moves on every
//   cycle that the output register is empty or taken.
// Stall: when color.ready is low the pipeline holds and squeezes out
//   bubbles; normal.ready drops only once every stage holds a word.
// Reset: all stages empty, registers at their defaults (light along +z,
//   white diffuse, no ambient or emissive). Color terms derived from the
//   registers are registered in the cycle after a write.
module vertex_lambert_lighting (
    input  logic                            clk,
    input  logic                            rst_n,
    vll_normal_if.sink                      normal,
    vll_color_if.source                     color,
    input  logic                            cfg_we,
    input  logic [vll_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vll_pkg::COLOR_W-1:0]     cfg_data
);

    vll_pkg::dir_t              light_dir;
    vll_pkg::shade_t            shade;
    logic                       dot_valid;
    logic                       dot_ready;
    logic [vll_pkg::DOT_W-1:0]  dot24;

    vll_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .light_dir (light_dir),
        .shade     (shade)
    );

    vll_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .light_dir (light_dir),
        .normal    (normal),
        .dot_valid (dot_valid),
        .dot_ready (dot_ready),
        .dot24     (dot24)
    );

    vll_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .shade     (shade),
        .dot_valid (dot_valid),
        .dot_ready (dot_ready),
        .dot24     (dot24),
        .color     (color)
    );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int unsigned {
        SINK_FREE,
        SINK_RANDOM,
        SINK_BLOCKS,
        SINK_ALTERNATE
    } sink_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [vll_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vll_pkg::COLOR_W-1:0]   cfg_data;

    vll_normal_if normal_bus ();
    vll_color_if  color_bus ();

    vertex_lambert_lighting dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .normal    (normal_bus),
        .color     (color_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the light and material registers
    vll_pkg::dir_t light_dir;
    vll_pkg::rgb_t mat_amb;
    vll_pkg::rgb_t mat_emis;
    vll_pkg::rgb_t mat_dif;
    vll_pkg::rgb_t lt_amb;
    vll_pkg::rgb_t lt_dif;

    logic [31:0] expected_colors[$];

    int unsigned normals_sent;
    int unsigned colors_checked;
    int unsigned light_settings;
    int unsigned mismatches;
    int unsigned burst_left;

    sink_mode_t  sink_mode;
    int unsigned sink_mode_left;
    int unsigned stall_left;
    logic        sink_ready;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] shade_vertex(input vll_pkg::dir_t n);
        longint          dot_sum;
        longint unsigned dot_mag;
        longint unsigned dot24;
        longint unsigned term;
        int unsigned     amb;
        int unsigned     dif;
        logic [31:0]     argb;
        dot_sum = longint'($signed(n.x)) * longint'($signed(light_dir.x))
                + longint'($signed(n.y)) * longint'($signed(light_dir.y))
                + longint'($signed(n.z)) * longint'($signed(light_dir.z));
        // two-sided: back faces light the same as front faces
        dot_mag = (dot_sum < 0) ? -dot_sum : dot_sum;
        dot24 = (dot_mag * 64'hFFFFFF) >> 30;
        if (dot24 > vll_pkg::DOT_MAX)
            dot24 = vll_pkg::DOT_MAX;
        argb = {vll_pkg::ALPHA, 24'h0};
        for (int c = 0; c < vll_pkg::CH_CNT; c++)
        begin
            amb = 32'(mat_amb[c]) * 32'(lt_amb[c]) / 255 + 32'(mat_emis[c]);
            if (amb > 255)
                amb = 255;
            dif = 32'(mat_dif[c]) * 32'(lt_dif[c]) / 255;
            if (dif > 255 - amb)
                dif = 255 - amb;
            term = ((64'(dif) * dot24) >> 24) + 64'(amb);
            argb[8*c +: 8] = term[7:0];
        end
        return argb;
    endfunction

    function automatic logic [15:0] random_q15();
        logic [15:0] corner[6] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                                   16'h0001, 16'h7FFF};
        case ($urandom_range(0, 9))
            0:       return corner[$urandom_range(0, 5)];
            1:       return 16'($signed(10'($urandom)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_rgb();
        return {random_byte(), random_byte(), random_byte()};
    endfunction

    // upper byte is junk the block must drop
    function automatic logic [23:0] random_dir_word();
        return {8'($urandom), random_q15()};
    endfunction

    function automatic vll_pkg::dir_t random_normal();
        vll_pkg::dir_t n;
        n.x = random_q15();
        n.y = random_q15();
        n.z = random_q15();
        return n;
    endfunction

    task automatic set_register(input vll_pkg::reg_idx_t idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            vll_pkg::REG_LIGHT_DIR_X:       light_dir.x = value[15:0];
            vll_pkg::REG_LIGHT_DIR_Y:       light_dir.y = value[15:0];
            vll_pkg::REG_LIGHT_DIR_Z:       light_dir.z = value[15:0];
            vll_pkg::REG_MAT_AMBIENT_RGB:   mat_amb     = value;
            vll_pkg::REG_MAT_EMISSIVE_RGB:  mat_emis    = value;
            vll_pkg::REG_MAT_DIFFUSE_RGB:   mat_dif     = value;
            vll_pkg::REG_LIGHT_AMBIENT_RGB: lt_amb      = value;
            default:                        lt_dif      = value;
        endcase
    endtask

    // derived color terms settle in the cycle after the last write
    task automatic finish_config();
        cfg_we <= 1'b0;
        repeat (3) @(posedge clk);
        light_settings++;
    endtask

    task automatic drain_pipeline();
        normal_bus.valid <= 1'b0;
        burst_left = 0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_normal(input vll_pkg::dir_t n);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 10);
                normal_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        normal_bus.valid    <= 1'b1;
        normal_bus.normal_x <= n.x;
        normal_bus.normal_y <= n.y;
        normal_bus.normal_z <= n.z;
        @(posedge clk);
        while (!normal_bus.ready)
            @(posedge clk);
        expected_colors.push_back(shade_vertex(n));
        normals_sent++;
    endtask

    // light along +z out of reset: facing, back-facing, edge-on, half-lit
    task automatic test_default_light();
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h7FFF});
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h8000});
        send_normal('{x: 16'h7FFF, y: 16'h0000, z: 16'h0000});
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h4000});
    endtask

    // oversized vectors saturate the dot; junk in the upper data bits
    task automatic test_direction_extremes();
        drain_pipeline();
        set_register(vll_pkg::REG_LIGHT_DIR_X, 24'hA58000);
        set_register(vll_pkg::REG_LIGHT_DIR_Y, 24'h5A8000);
        set_register(vll_pkg::REG_LIGHT_DIR_Z, 24'hFF8000);
        finish_config();
        send_normal('{x: 16'h8000, y: 16'h8000, z: 16'h8000});
        send_normal('{x: 16'h7FFF, y: 16'h7FFF, z: 16'h7FFF});
        send_normal('{x: 16'hFFFF, y: 16'hFFFF, z: 16'hFFFF});
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h0000});
        drain_pipeline();
        set_register(vll_pkg::REG_LIGHT_DIR_X, 24'hFF7FFF);
        set_register(vll_pkg::REG_LIGHT_DIR_Y, 24'h018000);
        set_register(vll_pkg::REG_LIGHT_DIR_Z, 24'h800001);
        finish_config();
        send_normal('{x: 16'h7FFF, y: 16'h8000, z: 16'h0001});
        send_normal('{x: 16'h8000, y: 16'h7FFF, z: 16'hFFFF});
    endtask

    // ambient past 255 leaves no room for diffuse; partial ambient clamps it
    task automatic test_ambient_saturation();
        drain_pipeline();
        set_register(vll_pkg::REG_LIGHT_DIR_X, 24'h000000);
        set_register(vll_pkg::REG_LIGHT_DIR_Y, 24'h000000);
        set_register(vll_pkg::REG_LIGHT_DIR_Z, 24'h007FFF);
        set_register(vll_pkg::REG_MAT_AMBIENT_RGB, 24'hFFFFFF);
        set_register(vll_pkg::REG_LIGHT_AMBIENT_RGB, 24'hFFFFFF);
        set_register(vll_pkg::REG_MAT_EMISSIVE_RGB, 24'h808080);
        finish_config();
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h7FFF});
        send_normal('{x: 16'h1234, y: 16'h0000, z: 16'hFB2E});
        drain_pipeline();
        set_register(vll_pkg::REG_MAT_EMISSIVE_RGB, 24'h000000);
        set_register(vll_pkg::REG_MAT_AMBIENT_RGB, 24'h808080);
        finish_config();
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h7FFF});
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'hC000});
    endtask

    task automatic test_color_extremes();
        drain_pipeline();
        set_register(vll_pkg::REG_MAT_AMBIENT_RGB, 24'h000000);
        set_register(vll_pkg::REG_LIGHT_AMBIENT_RGB, 24'h000000);
        set_register(vll_pkg::REG_MAT_DIFFUSE_RGB, 24'h000000);
        set_register(vll_pkg::REG_LIGHT_DIFFUSE_RGB, 24'h000000);
        finish_config();
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h7FFF});
        drain_pipeline();
        set_register(vll_pkg::REG_MAT_DIFFUSE_RGB, 24'hFF00FF);
        set_register(vll_pkg::REG_LIGHT_DIFFUSE_RGB, 24'hFFFF00);
        set_register(vll_pkg::REG_MAT_EMISSIVE_RGB, 24'h0000FF);
        finish_config();
        send_normal('{x: 16'h0000, y: 16'h0000, z: 16'h8000});
        send_normal('{x: 16'h2000, y: 16'hE000, z: 16'h5A82});
    endtask

    task automatic test_random_lighting();
        logic [23:0] value;
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_pipeline();
            for (int r = 0; r < 8; r++)
            begin
                value = (r < 3) ? random_dir_word() : random_rgb();
                case (phase)
                    0: value = (r < 3) ? {8'($urandom), 16'h8000} : 24'hFFFFFF;
                    1:
                    begin
                        if (r < 3)
                            value = {8'($urandom), 16'h7FFF};
                        else if (vll_pkg::reg_idx_t'(r) == vll_pkg::REG_MAT_DIFFUSE_RGB
                                 || vll_pkg::reg_idx_t'(r) == vll_pkg::REG_LIGHT_DIFFUSE_RGB)
                            value = 24'hFFFFFF;
                        else
                            value = 24'h000000;
                    end
                    2: if (r < 3) value = {8'($urandom), 16'h0000};
                    default: ;
                endcase
                set_register(vll_pkg::reg_idx_t'(r), value);
            end
            finish_config();
            repeat (100) send_normal(random_normal());
        end
    endtask

    // color sink: check each word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && color_bus.valid && color_bus.ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $display("%0t: unexpected color word %08h, none expected",
                         $time, color_bus.argb_color);
                mismatches++;
            end
            else
            begin
                if (color_bus.argb_color !== expected_colors[0])
                begin
                    $display("%0t: argb_color mismatch: expected %08h, actual %08h",
                             $time, expected_colors[0], color_bus.argb_color);
                    mismatches++;
                end
                void'(expected_colors.pop_front());
                colors_checked++;
            end
        end
        if (sink_mode_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_mode_left = $urandom_range(20, 150);
        end
        else
            sink_mode_left--;
        case (sink_mode)
            SINK_FREE:   sink_ready = 1'b1;
            SINK_RANDOM: sink_ready = 1'($urandom_range(0, 1));
            SINK_BLOCKS:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    sink_ready = 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(2, 14);
                    sink_ready = 1'b0;
                end
                else
                    sink_ready = 1'b1;
            end
            default:     sink_ready = ~sink_ready;
        endcase
        color_bus.ready <= sink_ready;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = vll_pkg::REG_LIGHT_DIR_X;
        cfg_data            = '0;
        normal_bus.valid    = 1'b0;
        normal_bus.normal_x = '0;
        normal_bus.normal_y = '0;
        normal_bus.normal_z = '0;
        color_bus.ready     = 1'b0;
        sink_ready          = 1'b0;
        sink_mode           = SINK_FREE;
        sink_mode_left      = 0;
        stall_left          = 0;
        burst_left          = 0;
        normals_sent        = 0;
        colors_checked      = 0;
        light_settings      = 1;
        mismatches          = 0;
        light_dir.x         = 16'h0000;
        light_dir.y         = 16'h0000;
        light_dir.z         = 16'h7FFF;
        mat_amb             = 24'h000000;
        mat_emis            = 24'h000000;
        mat_dif             = 24'hFFFFFF;
        lt_amb              = 24'h000000;
        lt_dif              = 24'hFFFFFF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_light();
        test_direction_extremes();
        test_ambient_saturation();
        test_color_extremes();
        test_random_lighting();
        drain_pipeline();

        $display("lit %0d normals under %0d light/material settings, %0d colors checked",
                 normals_sent, light_settings, colors_checked);
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d colors outstanding", expected_colors.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
